/* rtl/rsce_pkg.sv */
`default_nettype none

package rsce_pkg;

  // field widths
  localparam int unsigned FuncW    = 3;
  localparam int unsigned NameW    = 8;
  localparam int unsigned OpW      = 5;
  localparam int unsigned RegW     = 4;
  localparam int unsigned SpillW   = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned MaxRes   = 3;

  // register count after reset
  localparam logic [RegW-1:0] RegCountReset = 4'd4;

  // input operation codes
  localparam logic [FuncW-1:0] FUNC_LDL   = 3'd0;
  localparam logic [FuncW-1:0] FUNC_LDG   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_NEG   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_ADD   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_MUL   = 3'd4;
  localparam logic [FuncW-1:0] FUNC_SUB   = 3'd5;
  localparam logic [FuncW-1:0] FUNC_DIV   = 3'd6;
  localparam logic [FuncW-1:0] FUNC_FLUSH = 3'd7;

  // emitted instruction codes
  localparam logic [OpW-1:0] OP_PUSH     = 5'd0;
  localparam logic [OpW-1:0] OP_POP      = 5'd1;
  localparam logic [OpW-1:0] OP_LDL      = 5'd2;
  localparam logic [OpW-1:0] OP_LDG      = 5'd3;
  localparam logic [OpW-1:0] OP_NEG      = 5'd4;
  localparam logic [OpW-1:0] OP_ADDR     = 5'd5;
  localparam logic [OpW-1:0] OP_MULR     = 5'd6;
  localparam logic [OpW-1:0] OP_SWAP     = 5'd7;
  localparam logic [OpW-1:0] OP_SUBR     = 5'd8;
  localparam logic [OpW-1:0] OP_DIVR     = 5'd9;
  localparam logic [OpW-1:0] OP_MEM_BASE = 5'd10;

  // pending load kinds
  localparam logic [KindW-1:0] KIND_NONE   = 2'd0;
  localparam logic [KindW-1:0] KIND_LOCAL  = 2'd1;
  localparam logic [KindW-1:0] KIND_GLOBAL = 2'd2;

  // capital letters select the global memory form
  localparam logic [NameW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [NameW-1:0] CHAR_UPPER_Z = 8'h5A;

  localparam logic [SpillW-1:0] SpillMax = 8'hFF;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [NameW-1:0] var_name;
  } in_item_t;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [RegW-1:0]  reg_a;
    logic [RegW-1:0]  reg_b;
    logic [NameW-1:0] operand_name;
    logic             last;
  } out_item_t;

  // all instructions caused by one input, first in slot zero
  typedef struct packed {
    out_item_t [MaxRes-1:0] res;
  } bundle_t;

  // handshake between two stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

/* rtl/rsce_front.sv */
`default_nettype none

module rsce_front
  import rsce_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [RegW-1:0] reg_count_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_item_t        in_data_i,
  output hs_t                  q_hs_o,
  input  wire hs_t             q_hs_i,
  output bundle_t              q_data_o
);

  logic [RegW-1:0]   top_q, top_d;
  logic [SpillW-1:0] sd_q, sd_d;
  logic [KindW-1:0]  pk_q, pk_d;
  logic [NameW-1:0]  pn_q, pn_d;

  logic      in_fire;
  logic [1:0] n;
  bundle_t   bnd;
  logic [RegW-1:0] regs;
  logic [RegW-1:0] rb;
  logic [1:0] which;
  logic       glob;
  logic [OpW-1:0] rr_op;

  assign regs    = (reg_count_i == '0) ? RegW'(1) : reg_count_i;
  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = q_hs_i.ready;

  // decode one beat into its instruction bundle and next state
  always_comb begin
    top_d = top_q;
    sd_d  = sd_q;
    pk_d  = pk_q;
    pn_d  = pn_q;
    n     = 2'd0;
    bnd   = '0;
    rb    = '0;
    which = in_data_i.func[1:0] - 2'd3;
    glob  = (pn_q >= CHAR_UPPER_A) && (pn_q <= CHAR_UPPER_Z);
    rr_op = OP_ADDR;

    // pending load goes out first for loads, negate and flush
    if ((in_data_i.func == FUNC_LDL || in_data_i.func == FUNC_LDG ||
         in_data_i.func == FUNC_NEG || in_data_i.func == FUNC_FLUSH) &&
        pk_q != KIND_NONE) begin
      if (top_d >= regs) begin
        top_d = RegW'(1);
        bnd.res[n] = '{OP_PUSH, top_d, '0, '0, 1'b0};
        n = n + 2'd1;
        if (sd_d != SpillMax) sd_d = sd_d + SpillW'(1);
      end else if (sd_d != '0) begin
        top_d = top_d + RegW'(1);
        bnd.res[n] = '{OP_PUSH, top_d, '0, '0, 1'b0};
        n = n + 2'd1;
        if (sd_d != SpillMax) sd_d = sd_d + SpillW'(1);
      end else begin
        top_d = top_d + RegW'(1);
      end
      if (pk_q == KIND_LOCAL) begin
        bnd.res[n] = '{OP_LDL, top_d, '0, pn_q, 1'b0};
        n = n + 2'd1;
      end else if (pk_q == KIND_GLOBAL) begin
        bnd.res[n] = '{OP_LDG, top_d, '0, pn_q, 1'b0};
        n = n + 2'd1;
      end
      pk_d = KIND_NONE;
    end

    unique case (in_data_i.func)
      FUNC_LDL: begin
        pk_d = KIND_LOCAL;
        pn_d = in_data_i.var_name;
      end
      FUNC_LDG: begin
        pk_d = KIND_GLOBAL;
        pn_d = in_data_i.var_name;
      end
      FUNC_NEG: begin
        bnd.res[n] = '{OP_NEG, top_d, '0, '0, 1'b0};
        n = n + 2'd1;
      end
      FUNC_ADD, FUNC_MUL, FUNC_SUB, FUNC_DIV: begin
        if (pk_q != KIND_NONE) begin
          // fold the pending variable into a memory operand
          bnd.res[0] = '{OP_MEM_BASE + OpW'({which, glob}), top_q, '0, pn_q, 1'b0};
          n = 2'd1;
          pk_d = KIND_NONE;
        end else begin
          rb = (top_q < RegW'(2)) ? regs : top_q - RegW'(1);
          unique case (which)
            2'd0: rr_op = OP_ADDR;
            2'd1: rr_op = OP_MULR;
            2'd2: rr_op = OP_SUBR;
            default: rr_op = OP_DIVR;
          endcase
          if (which[1]) begin
            bnd.res[n] = '{OP_SWAP, top_q, rb, '0, 1'b0};
            n = n + 2'd1;
          end
          bnd.res[n] = '{rr_op, top_q, rb, '0, 1'b0};
          n = n + 2'd1;
          // pop, with fill on underflow
          if (top_q <= RegW'(1)) begin
            bnd.res[n] = '{OP_POP, top_q, '0, '0, 1'b0};
            n = n + 2'd1;
            top_d = regs;
            if (sd_q != '0) sd_d = sd_q - SpillW'(1);
          end else if (sd_q != '0) begin
            bnd.res[n] = '{OP_POP, top_q, '0, '0, 1'b0};
            n = n + 2'd1;
            sd_d  = sd_q - SpillW'(1);
            top_d = top_q - RegW'(1);
          end else begin
            top_d = top_q - RegW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // mark the final instruction
    if (n != 2'd0) bnd.res[n - 2'd1].last = 1'b1;
  end

  assign q_hs_o.valid = in_fire && (n != 2'd0);
  assign q_hs_o.ready = in_fire;
  assign q_data_o     = bnd;

  // stack state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      sd_q  <= '0;
      pk_q  <= KIND_NONE;
      pn_q  <= '0;
    end else if (in_fire) begin
      top_q <= top_d;
      sd_q  <= sd_d;
      pk_q  <= pk_d;
      pn_q  <= pn_d;
    end
  end

`ifndef SYNTH
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == FUNC_FLUSH |=> pk_q == KIND_NONE)
    else $error("flush left a pending load");

  a_spill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (sd_q == $past(sd_q)) || (sd_q == $past(sd_q) + SpillW'(1)) ||
                (sd_q == $past(sd_q) - SpillW'(1)))
    else $error("spill depth moved by more than one");

  a_bundle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_hs_o.valid |-> bnd.res[n - 2'd1].last)
    else $error("bundle without a final instruction");
`endif

endmodule

`default_nettype wire

/* rtl/rsce_queue.sv */
`default_nettype none

module rsce_queue
  import rsce_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  output logic         ready_o,
  input  wire bundle_t data_i,
  output logic         valid_o,
  input  wire logic    pop_i,
  output bundle_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("fill count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

/* rtl/rsce_back.sv */
`default_nettype none

module rsce_back
  import rsce_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  output logic         q_pop_o,
  input  wire bundle_t q_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_data_o
);

  bundle_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       cur_last;
  logic       load;

  assign out_data_o  = cur_q.res[idx_q];
  assign out_valid_o = cur_valid_q;
  assign cur_last    = cur_q.res[idx_q].last;
  assign load        = !cur_valid_q || (out_ready_i && cur_last);
  assign q_pop_o     = load && q_valid_i;

  // walk through the bundle one beat at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      cur_valid_q <= q_valid_i;
      idx_q       <= '0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> idx_q != 2'd3)
    else $error("result index past the bundle");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !out_ready_i |=> cur_valid_q && $stable(idx_q))
    else $error("stalled result moved");

  a_no_pop_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !cur_last |-> !q_pop_o)
    else $error("new bundle taken before the last beat");
`endif

endmodule

`default_nettype wire

/* rtl/register_stack_code_emitter.sv */
// channel | direction | payload         | handshake
// in      | input     | func, var_name  | in_valid_i / in_ready_o
// out     | output    | instruction     | out_valid_o / out_ready_i
// cfg     | input     | register count  | cfg_valid_i / cfg_ready_o
//
// an input beat is taken every cycle while the bundle queue has room
// each input yields zero to three instruction beats, sent by the back end one per
// cycle while out_ready_i is high; inputs queue up while older bundles drain
// first instruction passes the bundle queue and the back end's bundle register
// reset clears stack state, queue and output; register count returns to 4
`default_nettype none

module register_stack_code_emitter
  import rsce_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_item_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_item_t            out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [RegW-1:0] cfg_data_i
);

  logic [RegW-1:0] reg_count_q;
  hs_t             fq_hs, qf_hs;
  bundle_t         fq_data, qb_data;
  logic            q_valid, q_pop, q_ready;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_count_q <= RegCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      reg_count_q <= cfg_data_i;
    end
  end

  assign qf_hs.valid = q_valid;
  assign qf_hs.ready = q_ready;

  rsce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reg_count_i (reg_count_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_hs_o      (fq_hs),
    .q_hs_i      (qf_hs),
    .q_data_o    (fq_data)
  );

  rsce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_hs.valid),
    .ready_o (q_ready),
    .data_i  (fq_data),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (qb_data)
  );

  rsce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (qb_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_hs.valid |-> q_ready)
    else $error("bundle pushed into a full queue");

  a_accept_on_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_hs.ready |-> in_valid_i && q_ready)
    else $error("input taken without queue room");

  a_out_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_valid))
    else $error("result shown without a queued bundle");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsce_pkg::*;

  localparam int unsigned CycleLimit = 150000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned IdlePct    = 13;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [RegW-1:0] cfg_data;

  register_stack_code_emitter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // emitter state mirror
  logic [RegW-1:0]   reg_count;
  logic [RegW-1:0]   top_idx;
  logic [SpillW-1:0] spill_lvl;
  logic [KindW-1:0]  load_kind;
  logic [NameW-1:0]  load_name;

  out_item_t expected_instrs[$];
  out_item_t step_instrs[$];
  int        fail_count;
  int        cycle_count;
  bit        no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
  end

  // compare each instruction beat with the oldest expectation
  always @(posedge clk_i) begin : check_instr
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_instrs.size() == 0) begin
        $error("instruction beat with nothing expected: op %0d a %0d b %0d name %0d",
               out_data.opcode, out_data.reg_a, out_data.reg_b, out_data.operand_name);
        fail_count++;
      end else begin
        want = expected_instrs.pop_front();
        if (out_data.opcode !== want.opcode) begin
          $error("opcode: expected %0d, actual %0d", want.opcode, out_data.opcode);
          fail_count++;
        end
        if (out_data.reg_a !== want.reg_a) begin
          $error("reg_a: expected %0d, actual %0d", want.reg_a, out_data.reg_a);
          fail_count++;
        end
        if (out_data.reg_b !== want.reg_b) begin
          $error("reg_b: expected %0d, actual %0d", want.reg_b, out_data.reg_b);
          fail_count++;
        end
        if (out_data.operand_name !== want.operand_name) begin
          $error("operand_name: expected %0d, actual %0d", want.operand_name,
                 out_data.operand_name);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------- instruction predictor ----------------

  function automatic logic [RegW-1:0] live_regs();
    return (reg_count == '0) ? RegW'(1) : reg_count;
  endfunction

  task automatic emit_instr(input logic [OpW-1:0] op, input logic [RegW-1:0] a,
                            input logic [RegW-1:0] b, input logic [NameW-1:0] nm);
    out_item_t it;
    if (step_instrs.size() < MaxRes) begin
      it.opcode       = op;
      it.reg_a        = a;
      it.reg_b        = b;
      it.operand_name = nm;
      it.last         = 1'b0;
      step_instrs.push_back(it);
    end
  endtask

  // register-register form, second operand wraps below two
  task automatic emit_reg_pair(input logic [OpW-1:0] op);
    logic [RegW-1:0] second;
    second = (top_idx < 2) ? live_regs() : top_idx - 1'b1;
    emit_instr(op, top_idx, second, '0);
  endtask

  // push with spill on wrap
  task automatic spill_push();
    if (top_idx >= live_regs()) begin
      top_idx = RegW'(1);
      emit_instr(OP_PUSH, top_idx, '0, '0);
      if (spill_lvl != SpillMax) spill_lvl++;
    end else if (spill_lvl != 0) begin
      top_idx++;
      emit_instr(OP_PUSH, top_idx, '0, '0);
      if (spill_lvl != SpillMax) spill_lvl++;
    end else begin
      top_idx++;
    end
  endtask

  // pop with fill on underflow
  task automatic fill_pop();
    if (top_idx <= 1) begin
      emit_instr(OP_POP, top_idx, '0, '0);
      top_idx = live_regs();
      if (spill_lvl != 0) spill_lvl--;
    end else if (spill_lvl != 0) begin
      emit_instr(OP_POP, top_idx, '0, '0);
      spill_lvl--;
      top_idx--;
    end else begin
      top_idx--;
    end
  endtask

  task automatic flush_pending_load();
    if (load_kind != KIND_NONE) begin
      spill_push();
      if (load_kind == KIND_LOCAL) emit_instr(OP_LDL, top_idx, '0, load_name);
      else emit_instr(OP_LDG, top_idx, '0, load_name);
      load_kind = KIND_NONE;
    end
  endtask

  // fold a pending load into a memory operand, else register form and pop
  task automatic arith_op(input int unsigned which, input logic [OpW-1:0] reg_op);
    bit cap;
    if (load_kind != KIND_NONE) begin
      cap = (load_name >= CHAR_UPPER_A) && (load_name <= CHAR_UPPER_Z);
      emit_instr(OP_MEM_BASE + OpW'(2 * which + cap), top_idx, '0, load_name);
      load_kind = KIND_NONE;
    end else begin
      if (which >= 2) emit_reg_pair(OP_SWAP);
      emit_reg_pair(reg_op);
      fill_pop();
    end
  endtask

  task automatic predict_instrs(input in_item_t it);
    out_item_t tail;
    step_instrs.delete();
    case (it.func)
      FUNC_LDL, FUNC_LDG: begin
        flush_pending_load();
        load_kind = (it.func == FUNC_LDL) ? KIND_LOCAL : KIND_GLOBAL;
        load_name = it.var_name;
      end
      FUNC_NEG: begin
        flush_pending_load();
        emit_instr(OP_NEG, top_idx, '0, '0);
      end
      FUNC_ADD: arith_op(0, OP_ADDR);
      FUNC_MUL: arith_op(1, OP_MULR);
      FUNC_SUB: arith_op(2, OP_SUBR);
      FUNC_DIV: arith_op(3, OP_DIVR);
      default:  flush_pending_load();
    endcase
    if (step_instrs.size() > 0) begin
      tail = step_instrs.pop_back();
      tail.last = 1'b1;
      step_instrs.push_back(tail);
    end
    foreach (step_instrs[i]) expected_instrs.push_back(step_instrs[i]);
  endtask

  // ---------------- drivers ----------------

  // one input beat, with random gaps ahead of it
  task automatic send_op(input logic [FuncW-1:0] f, input logic [NameW-1:0] nm);
    in_item_t it;
    it.func     = f;
    it.var_name = nm;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    predict_instrs(it);
  endtask

  // stop sending and wait out every expected beat
  task automatic drain_all();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_instrs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg_count(input logic [RegW-1:0] n);
    drain_all();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk_i); while (!cfg_ready);
    reg_count = n;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [NameW-1:0] rand_name();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return NameW'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
    if (r < 7) return NameW'($urandom_range(8'h61, 8'h7A));
    return NameW'($urandom_range(0, 255));
  endfunction

  // mostly well formed postfix, some noise
  task automatic send_random_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) send_op(($urandom_range(0, 1) != 0) ? FUNC_LDG : FUNC_LDL, rand_name());
    else if (r < 70) send_op(FuncW'($urandom_range(FUNC_ADD, FUNC_DIV)), rand_name());
    else if (r < 82) send_op(FUNC_NEG, rand_name());
    else if (r < 92) send_op(FUNC_FLUSH, rand_name());
    else send_op(FuncW'($urandom_range(0, 7)), NameW'($urandom_range(0, 255)));
  endtask

  // ---------------- tests ----------------

  // every operation, name boundaries, empty stack corners
  task automatic test_directed();
    write_reg_count(RegCountReset);
    send_op(FUNC_FLUSH, 8'hFF);     // nothing pending
    send_op(FUNC_NEG, 8'h00);       // neg with nothing pending
    send_op(FUNC_ADD, 8'h00);       // fill without spill
    send_op(FUNC_LDL, 8'h61);
    send_op(FUNC_ADD, 8'h00);       // local form
    send_op(FUNC_LDG, CHAR_UPPER_Z);
    send_op(FUNC_MUL, 8'h00);       // global form
    send_op(FUNC_LDL, CHAR_UPPER_A);
    send_op(FUNC_SUB, 8'h00);
    send_op(FUNC_LDG, 8'h40);
    send_op(FUNC_DIV, 8'h00);       // just below capitals
    send_op(FUNC_LDL, 8'h5B);
    send_op(FUNC_ADD, 8'h00);       // just above capitals
    send_op(FUNC_LDL, 8'h00);
    send_op(FUNC_LDG, 8'hFF);       // load while pending
    send_op(FUNC_NEG, 8'h00);       // neg with pending load
    send_op(FUNC_LDL, 8'h7A);
    send_op(FUNC_FLUSH, 8'h00);     // flush with pending load
    send_op(FUNC_SUB, 8'h00);       // swap, subr, pop
    send_op(FUNC_DIV, 8'h00);
    send_op(FUNC_MUL, 8'hAA);
    send_op(FUNC_ADD, 8'h55);
  endtask

  // one register, long load chain until the spill depth pins, then unwind
  task automatic test_spill_saturation();
    write_reg_count(RegW'(1));
    no_idle = 1'b1;
    repeat (265) begin
      send_op(($urandom_range(0, 1) != 0) ? FUNC_LDG : FUNC_LDL, rand_name());
    end
    no_idle = 1'b0;
    send_op(FUNC_FLUSH, rand_name());
    repeat (15) send_op(FuncW'($urandom_range(FUNC_ADD, FUNC_DIV)), rand_name());
  endtask

  // random traffic over several register counts
  task automatic test_random_phases();
    logic [RegW-1:0] counts[5];
    counts[0] = '0;
    counts[1] = RegW'(15);
    counts[2] = RegW'(2);
    counts[3] = RegW'($urandom_range(3, 14));
    counts[4] = RegW'($urandom_range(0, 15));
    for (int p = 0; p < 5; p++) begin
      write_reg_count(counts[p]);
      no_idle = (p == 2);
      for (int i = 0; i < 32; i++) begin
        if (p == 1 && i == 16) drain_all();   // sender holds until all came back
        send_random_op();
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------- main ----------------

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    fail_count  = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    reg_count   = RegCountReset;
    top_idx     = '0;
    spill_lvl   = '0;
    load_kind   = KIND_NONE;
    load_name   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_spill_saturation();
    test_random_phases();
    drain_all();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rsce_pkg.sv
rtl/rsce_front.sv
rtl/rsce_queue.sv
rtl/rsce_back.sv
rtl/register_stack_code_emitter.sv
sim/tb.sv
